### sv/adaptive_baseline_denoise_assert.svh
// ---------------------------------------------------------------------------
// adaptive baseline denoise assertion macros
// shared property forms, clocked on clock and disabled during reset
// ---------------------------------------------------------------------------
`ifndef ADAPTIVE_BASELINE_DENOISE_ASSERT_SVH
`define ADAPTIVE_BASELINE_DENOISE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define ABD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ABD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/abd_pkg.sv
// ---------------------------------------------------------------------------
// abd_pkg
// types and fixed constants shared by the adaptive baseline denoise block
// ---------------------------------------------------------------------------
package abd_pkg;

   // sigma = mean * 1.2533141, as 82137 / 65536
   localparam logic [16:0] SIGMA_GAIN = 17'd82137;
   // unity ratio in q1.16
   localparam logic [16:0] RATIO_ONE  = 17'h10000;
   // quotient bits produced by the ratio divider
   localparam int          DIV_STEPS  = 16;

   // csr register indexes
   localparam logic [3:0] CSR_RATE_MIN      = 4'd0;
   localparam logic [3:0] CSR_RATE_MAX      = 4'd1;
   localparam logic [3:0] CSR_NOISE_RATE    = 4'd2;
   localparam logic [3:0] CSR_BASELINE_RATE = 4'd3;
   localparam logic [3:0] CSR_AMP_SCALE     = 4'd4;
   localparam logic [3:0] CSR_ERR_SCALE     = 4'd5;
   localparam logic [3:0] CSR_TRACK_LIMIT   = 4'd6;
   localparam logic [3:0] CSR_DEAD_BAND     = 4'd7;

   // one channel's stored state
   typedef struct packed {
      logic               started;
      logic [23:0]        baseline;
      logic [23:0]        mean_abs;
      logic signed [24:0] res_last;
      logic signed [24:0] res_older;
      logic signed [24:0] smooth_last;
   } chan_entry_type;

   // divider status towards the sequencer
   typedef struct packed {
      logic        done;
      logic [16:0] ratio;
   } div_stat_type;

endpackage

### sv/abd_chan_mem.sv
// ---------------------------------------------------------------------------
// abd_chan_mem
// per-channel state memory, one write and one registered read port
// ---------------------------------------------------------------------------
module abd_chan_mem import abd_pkg::*; #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic           clock,
   input  logic           we,
   input  logic [AW-1:0]  waddr,
   input  chan_entry_type wdata,
   input  logic           re,
   input  logic [AW-1:0]  raddr,
   output chan_entry_type rdata
);

   chan_entry_type mem [DEPTH];
   chan_entry_type rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### sv/abd_div.sv
// ---------------------------------------------------------------------------
// abd_div
// ratio divider: (mag << 24) / den in q0.16, one quotient bit per cycle
// ---------------------------------------------------------------------------
module abd_div import abd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [25:0]  mag,
   input  logic [40:0]  den,
   output div_stat_type stat
);

   logic [41:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [40:0] den_ff, den_in;
   logic        sat_ff, sat_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [41:0] shifted;
   logic        ge;

   // one restoring step, zeros are shifted in
   assign shifted = {rem_ff[40:0], 1'b0};
   assign ge      = shifted >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = 42'({mag, 8'b0});
         quo_in  = '0;
         den_in  = den;
         // zero denominator or ratio at or above one clamps to one
         sat_in  = (den == '0) || (41'({mag, 8'b0}) >= den);
         cnt_in  = 5'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? shifted - {1'b0, den_ff} : shifted;
         quo_in = {quo_ff[14:0], ge};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      sat_ff <= sat_in;
   end

   assign stat.done  = done_ff;
   assign stat.ratio = sat_ff ? RATIO_ONE : {1'b0, quo_ff};

endmodule

### sv/adaptive_baseline_denoise.sv
// ---------------------------------------------------------------------------
// adaptive_baseline_denoise
// per-channel baseline removal, median-of-three, noise tracking and
// adaptive-rate smoothing for a scanned sensor array
// ---------------------------------------------------------------------------
//  channel  | handshake          | payload
//  req_     | req_valid/ready    | req_channel, req_sample
//  rsp_     | rsp_valid/ready    | rsp_channel_out, rsp_level, rsp_first_sample
//  csr_     | csr_valid/ready    | csr_index, csr_data
//
// one transaction at a time; a warm sample passes through the two ratio dividers
// (start, 16 steps, done) before its result is loaded
// a cold-start or out-of-range channel goes from the read straight to its result
// req_ready rises the cycle after the result is loaded
// after reset a clearing pass over all CHANNELS entries runs before req_ready rises
// a waiting result in the output register holds the sequencer at its last step
// ---------------------------------------------------------------------------
module adaptive_baseline_denoise import abd_pkg::*; #(
   parameter int CHANNELS    = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [9:0]         req_channel,
   input  logic [15:0]        req_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [9:0]         rsp_channel_out,
   output logic signed [24:0] rsp_level,
   output logic               rsp_first_sample,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [15:0]        csr_data
);

   localparam int          AW          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

   typedef enum logic [14:0] {
      S_CLEAR = 15'b000000000000001,
      S_IDLE  = 15'b000000000000010,
      S_READ  = 15'b000000000000100,
      S_WIN   = 15'b000000000001000,
      S_MEAN  = 15'b000000000010000,
      S_SIG1  = 15'b000000000100000,
      S_SCALE = 15'b000000001000000,
      S_MULS  = 15'b000000010000000,
      S_DIV   = 15'b000000100000000,
      S_ALPHA = 15'b000001000000000,
      S_ASUM  = 15'b000010000000000,
      S_YMUL  = 15'b000100000000000,
      S_YSUM  = 15'b001000000000000,
      S_PREP  = 15'b010000000000000,
      S_OUT   = 15'b100000000000000
   } state_type;

   // rounded q16 step, ties away from zero on magnitudes
   function automatic logic [26:0] rnd16(input logic [42:0] p);
      logic [42:0] s;
      s = p + 43'd32768;
      return s[42:16];
   endfunction

   function automatic logic signed [24:0] mid3(input logic signed [24:0] a,
                                               input logic signed [24:0] b,
                                               input logic signed [24:0] c);
      logic signed [24:0] lo, hi, t;
      lo = (a > b) ? b : a;
      hi = (a > b) ? a : b;
      t  = (hi > c) ? c : hi;
      return (lo > t) ? lo : t;
   endfunction

   // ---------------- registers ----------------
   state_type          state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [15:0]        rate_min_ff, rate_max_ff, noise_rate_ff, baseline_rate_ff;
   logic [15:0]        amp_scale_ff, err_scale_ff, track_limit_ff, dead_band_ff;
   logic [9:0]         ch_ff;
   logic [23:0]        x_ff;
   logic               in_range_ff;
   logic signed [24:0] r0_ff, rmed_ff, y_ff;
   logic [23:0]        absr_ff, mean_ff;
   logic               wneg_ff, eneg_ff, aneg_ff;
   logic [42:0]        prod_ff, bprod_ff;
   logic [24:0]        sigma_ff;
   logic [25:0]        emag_ff, amag_ff;
   logic [40:0]        den_a_ff, den_e_ff, dead_ff, trk_ff;
   logic               div_go_ff;
   logic [15:0]        alpha_ff;
   chan_entry_type     wr_ent_ff;
   logic               wr_en_ff;
   logic signed [24:0] res_level_ff;
   logic               res_first_ff;
   logic               rsp_valid_ff;
   logic [9:0]         rsp_ch_ff;
   logic signed [24:0] rsp_level_ff;
   logic               rsp_first_ff;

   // ---------------- wires ----------------
   logic               req_acc;
   logic               out_free;
   chan_entry_type     rd;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   chan_entry_type     mem_wdata;
   logic [25:0]        mul_a;
   logic [16:0]        mul_b;
   logic [42:0]        mul_p;
   div_stat_type       stat_a, stat_e;
   logic signed [24:0] r0_c, rmed_c, wdiff_c, y_c;
   logic [23:0]        absr_c, mean_eff_c, w_c, bstep_c, base_new_c;
   logic [24:0]        sig0_c;
   logic [26:0]        four_sig_c;
   logic signed [25:0] ediff_c, y_wide_c;
   logic signed [16:0] dr_c;
   logic [16:0]        ratio_c;
   logic [24:0]        absy_c;
   logic [23:0]        mean_new_c;
   logic [26:0]        prod_rnd_c, bprod_rnd_c;
   logic               alpha_ok_c;

   assign req_ready = (state_ff == S_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   // ---------------- channel state memory ----------------
   assign mem_we    = (state_ff == S_CLEAR) || ((state_ff == S_OUT) && out_free && wr_en_ff);
   assign mem_waddr = (state_ff == S_CLEAR) ? clr_ff : AW'(ch_ff);
   assign mem_wdata = (state_ff == S_CLEAR) ? chan_entry_type'('0) : wr_ent_ff;

   abd_chan_mem #(.DEPTH(CHANNELS), .AW(AW)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (req_acc),
      .raddr (AW'(req_channel)),
      .rdata (rd)
   );

   // ---------------- ratio dividers ----------------
   abd_div u_div_amp (
      .clock (clock), .reset (reset), .start (div_go_ff),
      .mag (amag_ff), .den (den_a_ff), .stat (stat_a)
   );

   abd_div u_div_err (
      .clock (clock), .reset (reset), .start (div_go_ff),
      .mag (emag_ff), .den (den_e_ff), .stat (stat_e)
   );

   // ---------------- shared multiplier operands ----------------
   always_comb begin
      case (state_ff)
         S_READ:  begin mul_a = 26'(mean_eff_c);              mul_b = SIGMA_GAIN;            end
         S_WIN:   begin
            mul_a = 26'(wdiff_c[24] ? 25'(-wdiff_c) : wdiff_c);
            mul_b = {1'b0, noise_rate_ff};
         end
         S_SIG1:  begin mul_a = 26'((mean_ff == '0) ? 24'd1 : mean_ff); mul_b = SIGMA_GAIN; end
         S_SCALE: begin mul_a = 26'(absr_ff);                 mul_b = {1'b0, baseline_rate_ff}; end
         S_ALPHA: begin mul_a = 26'(dr_c[16] ? 17'(-dr_c) : dr_c); mul_b = ratio_c;          end
         S_YMUL:  begin mul_a = emag_ff;                      mul_b = {1'b0, alpha_ff};       end
         default: begin mul_a = '0;                           mul_b = '0;                     end
      endcase
   end

   assign mul_p = 43'(mul_a) * 43'(mul_b);

   // rounded products
   assign prod_rnd_c  = rnd16(prod_ff);
   assign bprod_rnd_c = rnd16(bprod_ff);

   // ---------------- datapath terms ----------------
   // residual, median and magnitude from the freshly read entry
   assign r0_c       = $signed({1'b0, x_ff}) - $signed({1'b0, rd.baseline});
   assign rmed_c     = mid3(rd.res_older, rd.res_last, r0_c);
   assign absr_c     = r0_c[24] ? 24'(-r0_c) : r0_c[23:0];
   assign mean_eff_c = (rd.mean_abs == '0) ? 24'd1 : rd.mean_abs;

   // winsorised input to the noise ema
   assign sig0_c     = prod_rnd_c[24:0];
   assign four_sig_c = {sig0_c, 2'b00};
   assign w_c        = (27'(absr_ff) < four_sig_c) ? absr_ff : four_sig_c[23:0];
   assign wdiff_c    = $signed({1'b0, w_c}) - $signed({1'b0, rd.mean_abs});

   // noise ema update
   assign mean_new_c = wneg_ff ? rd.mean_abs - prod_rnd_c[23:0]
                               : rd.mean_abs + prod_rnd_c[23:0];

   // tracking error against the last smoothed value
   assign ediff_c = {rmed_ff[24], rmed_ff} - {rd.smooth_last[24], rd.smooth_last};

   // rate interpolation
   assign ratio_c = (stat_a.ratio > stat_e.ratio) ? stat_a.ratio : stat_e.ratio;
   assign dr_c    = $signed({1'b0, rate_max_ff}) - $signed({1'b0, rate_min_ff});

   // smoothed value, its magnitude stays within the stored level range
   assign y_wide_c = eneg_ff ? {rd.smooth_last[24], rd.smooth_last} - $signed(prod_rnd_c[25:0])
                             : {rd.smooth_last[24], rd.smooth_last} + $signed(prod_rnd_c[25:0]);
   assign y_c      = y_wide_c[24:0];

   // dead band and baseline follow
   assign absy_c     = y_ff[24] ? 25'(-y_ff) : y_ff;
   assign bstep_c    = bprod_rnd_c[23:0];
   assign base_new_c = r0_ff[24] ? rd.baseline - bstep_c : rd.baseline + bstep_c;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(CHANNELS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE:  if (req_acc) state_in = S_READ;
         S_READ:  state_in = (!in_range_ff || !rd.started) ? S_OUT : S_WIN;
         S_WIN:   state_in = S_MEAN;
         S_MEAN:  state_in = S_SIG1;
         S_SIG1:  state_in = S_SCALE;
         S_SCALE: state_in = S_MULS;
         S_MULS:  state_in = S_DIV;
         S_DIV:   if (stat_a.done) state_in = S_ALPHA;
         S_ALPHA: state_in = S_ASUM;
         S_ASUM:  state_in = S_YMUL;
         S_YMUL:  state_in = S_YSUM;
         S_YSUM:  state_in = S_PREP;
         S_PREP:  state_in = S_OUT;
         S_OUT:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         div_go_ff <= (state_ff == S_MULS);
         if ((state_ff == S_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_min_ff      <= 16'd1311;
         rate_max_ff      <= 16'd32768;
         noise_rate_ff    <= 16'd3277;
         baseline_rate_ff <= 16'd655;
         amp_scale_ff     <= 16'd768;
         err_scale_ff     <= 16'd768;
         track_limit_ff   <= 16'd384;
         dead_band_ff     <= 16'd128;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RATE_MIN:      rate_min_ff      <= csr_data;
            CSR_RATE_MAX:      rate_max_ff      <= csr_data;
            CSR_NOISE_RATE:    noise_rate_ff    <= csr_data;
            CSR_BASELINE_RATE: baseline_rate_ff <= csr_data;
            CSR_AMP_SCALE:     amp_scale_ff     <= csr_data;
            CSR_ERR_SCALE:     err_scale_ff     <= csr_data;
            CSR_TRACK_LIMIT:   track_limit_ff   <= csr_data;
            CSR_DEAD_BAND:     dead_band_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // datapath registers, one step per state
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            ch_ff       <= req_channel;
            x_ff        <= {req_sample & SAMPLE_MASK, 8'b0};
            in_range_ff <= int'(req_channel) < CHANNELS;
         end
         S_READ: begin
            r0_ff        <= r0_c;
            rmed_ff      <= rmed_c;
            absr_ff      <= absr_c;
            prod_ff      <= mul_p;
            res_level_ff <= '0;
            res_first_ff <= in_range_ff && !rd.started;
            wr_en_ff     <= in_range_ff;
            // cold start sets up the channel
            wr_ent_ff    <= '{started: 1'b1, baseline: x_ff, mean_abs: '0,
                              res_last: '0, res_older: '0, smooth_last: '0};
         end
         S_WIN: begin
            wneg_ff <= wdiff_c[24];
            prod_ff <= mul_p;
         end
         S_MEAN:  mean_ff <= mean_new_c;
         S_SIG1:  prod_ff <= mul_p;
         S_SCALE: begin
            sigma_ff <= prod_rnd_c[24:0];
            bprod_ff <= mul_p;
            eneg_ff  <= ediff_c[25];
            emag_ff  <= ediff_c[25] ? 26'(-ediff_c) : ediff_c;
            amag_ff  <= 26'(rmed_ff[24] ? 25'(-rmed_ff) : rmed_ff);
         end
         S_MULS: begin
            den_a_ff <= 41'(amp_scale_ff) * 41'(sigma_ff);
            den_e_ff <= 41'(err_scale_ff) * 41'(sigma_ff);
            dead_ff  <= 41'(dead_band_ff) * 41'(sigma_ff);
            trk_ff   <= 41'(track_limit_ff) * 41'(sigma_ff);
         end
         S_ALPHA: begin
            aneg_ff <= dr_c[16];
            prod_ff <= mul_p;
         end
         S_ASUM: alpha_ff <= aneg_ff ? rate_min_ff - prod_rnd_c[15:0]
                                     : rate_min_ff + prod_rnd_c[15:0];
         S_YMUL: prod_ff <= mul_p;
         S_YSUM: y_ff    <= y_c;
         S_PREP: begin
            res_level_ff          <= (41'({absy_c, 8'b0}) < dead_ff) ? '0 : y_ff;
            wr_ent_ff.started     <= 1'b1;
            wr_ent_ff.baseline    <= (41'({absr_ff, 8'b0}) < trk_ff) ? base_new_c
                                                                     : rd.baseline;
            wr_ent_ff.mean_abs    <= mean_ff;
            wr_ent_ff.res_last    <= r0_ff;
            wr_ent_ff.res_older   <= rd.res_last;
            wr_ent_ff.smooth_last <= (41'({absy_c, 8'b0}) < dead_ff) ? '0 : y_ff;
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if ((state_ff == S_OUT) && out_free) begin
         rsp_ch_ff    <= ch_ff;
         rsp_level_ff <= res_level_ff;
         rsp_first_ff <= res_first_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_channel_out  = rsp_ch_ff;
   assign rsp_level        = rsp_level_ff;
   assign rsp_first_sample = rsp_first_ff;

   // rate lies between the two bounds, whichever way round they are
   assign alpha_ok_c = ((alpha_ff >= rate_min_ff) && (alpha_ff <= rate_max_ff)) ||
                       ((alpha_ff >= rate_max_ff) && (alpha_ff <= rate_min_ff));

   // ---------------- assertions ----------------
`include "adaptive_baseline_denoise_assert.svh"

   `ABD_ASSERT_NEXT(a_accept_reads, req_acc, state_ff == S_READ, "accept did not start a read")
   `ABD_ASSERT_NOW(a_write_place, mem_we, (state_ff == S_CLEAR) || (state_ff == S_OUT), "stray memory write")
   `ABD_ASSERT_NOW(a_first_zero, rsp_valid && rsp_first_sample, rsp_level == '0, "cold start with nonzero level")
   `ABD_ASSERT_NOW(a_div_sync, state_ff == S_DIV, stat_a.done == stat_e.done, "dividers out of step")
   `ABD_ASSERT_NOW(a_alpha_bounds, state_ff == S_YMUL, alpha_ok_c, "rate outside bounds")

endmodule

### dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// self-checking bench for adaptive_baseline_denoise: a directed table, then
// random channel sweeps under several register settings, each result checked
// in order against a cycle-free model of the per-channel filter state
// ---------------------------------------------------------------------------
module tb import abd_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCHAN     = 1024;
   localparam int LEVEL_MAX = 16777215;

   // one expected result
   typedef struct {
      logic [9:0]         chan;
      logic signed [24:0] level;
      logic               first;
   } denoise_result_type;

   // one directed row: known result typed in where obvious
   typedef struct {
      logic [9:0]         chan;
      logic [15:0]        sample;
      bit                 known;
      logic signed [24:0] level;
      logic               first;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [9:0]         req_channel = '0;
   logic [15:0]        req_sample = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [9:0]         rsp_channel_out;
   logic signed [24:0] rsp_level;
   logic               rsp_first_sample;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [3:0]         csr_index = '0;
   logic [15:0]        csr_data = '0;

   // shadow registers
   longint unsigned cfg [8];

   // shadow channel state
   bit     ch_started [NCHAN];
   longint ch_base [NCHAN];
   longint ch_mean [NCHAN];
   longint ch_rlast [NCHAN];
   longint ch_rolder [NCHAN];
   longint ch_smooth [NCHAN];

   denoise_result_type pending_results[$];
   int errors = 0;
   int n_checked = 0;
   int n_items = 0;
   bit rsp_stall_on = 1'b1;

   adaptive_baseline_denoise u_dut (.*);

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial begin
      #20ms;
      $display("tb failed");
      $finish;
   end

   function automatic longint ema_advance(longint prev, longint x, longint unsigned rate);
      longint d;
      longint unsigned mag, stp;
      d   = x - prev;
      mag = (d < 0) ? -d : d;
      stp = (mag * rate + 32768) >> 16;
      return (d < 0) ? prev - longint'(stp) : prev + longint'(stp);
   endfunction

   function automatic longint median3(longint a, longint b, longint c);
      longint t;
      if (a > b) begin t = a; a = b; b = t; end
      if (b > c) begin t = b; b = c; c = t; end
      if (a > b) begin t = a; a = b; b = t; end
      return b;
   endfunction

   function automatic longint unsigned noise_sigma(longint mean);
      longint unsigned m;
      m = (mean < 1) ? 1 : mean;
      return (m * 82137 + 32768) >> 16;
   endfunction

   function automatic longint unsigned magn(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint unsigned norm_ratio(longint unsigned mag,
         longint unsigned scale, longint unsigned sig);
      longint unsigned den, num;
      den = scale * sig;
      num = mag << 24;
      if (den == 0 || num >= den * 65536) return 65536;
      return num / den;
   endfunction

   // predict one result and advance the shadow state
   function automatic denoise_result_type denoise_predict(logic [9:0] ch, logic [15:0] smp);
      denoise_result_type res;
      longint x, r0, rmed, b0, y, alpha;
      longint unsigned sig, absr, w, ra, re, ratio;
      res.chan = ch; res.level = '0; res.first = 1'b0;
      x = longint'(smp) << 8;
      if (ch >= NCHAN) return res;
      if (!ch_started[ch]) begin
         ch_started[ch] = 1'b1;
         ch_base[ch] = x; ch_mean[ch] = 0;
         ch_rlast[ch] = 0; ch_rolder[ch] = 0; ch_smooth[ch] = 0;
         res.first = 1'b1;
         return res;
      end
      b0   = ch_base[ch];
      r0   = x - b0;
      rmed = median3(ch_rolder[ch], ch_rlast[ch], r0);
      sig  = noise_sigma(ch_mean[ch]);
      absr = magn(r0);
      w    = (absr < 4 * sig) ? absr : 4 * sig;
      ch_mean[ch] = ema_advance(ch_mean[ch], longint'(w), cfg[CSR_NOISE_RATE]);
      sig  = noise_sigma(ch_mean[ch]);
      re   = norm_ratio(magn(rmed - ch_smooth[ch]), cfg[CSR_ERR_SCALE], sig);
      ra   = norm_ratio(magn(rmed), cfg[CSR_AMP_SCALE], sig);
      ratio = (ra > re) ? ra : re;
      alpha = ema_advance(longint'(cfg[CSR_RATE_MIN]), longint'(cfg[CSR_RATE_MAX]), ratio);
      y = ema_advance(ch_smooth[ch], rmed, longint'(alpha));
      if ((magn(y) << 8) < cfg[CSR_DEAD_BAND] * sig) y = 0;
      if (y > LEVEL_MAX) y = LEVEL_MAX;
      if (y < -LEVEL_MAX) y = -LEVEL_MAX;
      if ((absr << 8) < cfg[CSR_TRACK_LIMIT] * sig)
         ch_base[ch] = ema_advance(b0, x, cfg[CSR_BASELINE_RATE]);
      ch_rolder[ch] = ch_rlast[ch];
      ch_rlast[ch]  = r0;
      ch_smooth[ch] = y;
      res.level = y[24:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   function automatic int gap_len();
      int p;
      p = int'($urandom_range(0, 99));
      if (p < 50) return 0;
      if (p < 90) return int'($urandom_range(1, 3));
      return int'($urandom_range(5, 40));
   endfunction

   // send one sample transaction after a random gap, valid drops after the handshake
   task automatic send_sample(logic [9:0] ch, logic [15:0] smp);
      repeat (gap_len()) @(posedge clock);
      req_valid   <= 1'b1;
      req_channel <= ch;
      req_sample  <= smp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(denoise_predict(ch, smp));
      n_items++;
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_reg(logic [3:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg[idx] = val;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // result side: random stalls and in-order comparison
   always @(posedge clock) begin
      denoise_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result on channel", rsp_channel_out, -1);
            end else begin
               want = pending_results.pop_front();
               n_checked++;
               if (rsp_channel_out !== want.chan)
                  report_mismatch("channel_out", rsp_channel_out, want.chan);
               if (rsp_level !== want.level)
                  report_mismatch("level", rsp_level, want.level);
               if (rsp_first_sample !== want.first)
                  report_mismatch("first_sample", rsp_first_sample, want.first);
            end
         end
         rsp_ready <= rsp_stall_on ? ($urandom_range(0, 9) < 7) : 1'b1;
      end
   end

   // random well-formed traffic: a few channels with a drifting base plus noise, now and then a random sample
   task automatic random_phase(int count, int nch, int noise);
      logic [9:0]  chs [8];
      int          base [8];
      int          k, v;
      for (int i = 0; i < nch; i++) begin
         chs[i]  = 10'($urandom_range(0, NCHAN - 1));
         base[i] = int'($urandom_range(0, 65535));
      end
      for (int n = 0; n < count; n++) begin
         k = int'($urandom_range(0, nch - 1));
         if ($urandom_range(0, 19) == 0)
            send_sample(10'($urandom), 16'($urandom));
         else begin
            base[k] += int'($urandom_range(0, 4)) - 2;
            v = base[k] + int'($urandom_range(0, 2 * noise)) - noise;
            if ($urandom_range(0, 15) == 0) v += int'($urandom_range(0, 8000)) - 4000;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            send_sample(chs[k], v[15:0]);
         end
      end
   endtask

   stim_row_type rows [$];

   initial begin
      denoise_result_type want;
      stim_row_type       row;
      cfg[CSR_RATE_MIN] = 1311;  cfg[CSR_RATE_MAX] = 32768;
      cfg[CSR_NOISE_RATE] = 3277; cfg[CSR_BASELINE_RATE] = 655;
      cfg[CSR_AMP_SCALE] = 768;  cfg[CSR_ERR_SCALE] = 768;
      cfg[CSR_TRACK_LIMIT] = 384; cfg[CSR_DEAD_BAND] = 128;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table: cold starts on three channels, warm samples, then a last cold start
      rows = '{
         '{10'd0,    16'h0000, 1'b1, 25'sd0, 1'b1},
         '{10'd1023, 16'hFFFF, 1'b1, 25'sd0, 1'b1},
         '{10'd5,    16'h8000, 1'b1, 25'sd0, 1'b1},
         '{10'd0,    16'h0000, 1'b0, 25'sd0, 1'b0},
         '{10'd0,    16'hFFFF, 1'b0, 25'sd0, 1'b0},
         '{10'd0,    16'hFFFF, 1'b0, 25'sd0, 1'b0},
         '{10'd0,    16'hFFFF, 1'b0, 25'sd0, 1'b0},
         '{10'd1023, 16'h0000, 1'b0, 25'sd0, 1'b0},
         '{10'd1023, 16'h0000, 1'b0, 25'sd0, 1'b0},
         '{10'd1023, 16'h0000, 1'b0, 25'sd0, 1'b0},
         '{10'd5,    16'h8001, 1'b0, 25'sd0, 1'b0},
         '{10'd5,    16'h7FFF, 1'b0, 25'sd0, 1'b0},
         '{10'd5,    16'h8000, 1'b0, 25'sd0, 1'b0},
         '{10'd5,    16'h9000, 1'b0, 25'sd0, 1'b0},
         '{10'd5,    16'h5555, 1'b0, 25'sd0, 1'b0},
         '{10'd5,    16'hAAAA, 1'b0, 25'sd0, 1'b0},
         '{10'd77,   16'h1234, 1'b1, 25'sd0, 1'b1}
      };
      foreach (rows[i]) begin
         row = rows[i];
         send_sample(row.chan, row.sample);
         if (row.known) begin
            want = pending_results[$];
            if (want.level !== row.level || want.first !== row.first)
               report_mismatch("table row", i, 0);
         end
      end
      wait_drained();

      // default registers
      random_phase(400, 4, 40);
      wait_drained();

      // extremes: zero scales force the rate to rate_max, rate_max below rate_min
      write_reg(CSR_RATE_MIN, 16'hFFFF);
      write_reg(CSR_RATE_MAX, 16'h0000);
      write_reg(CSR_NOISE_RATE, 16'hFFFF);
      write_reg(CSR_BASELINE_RATE, 16'hFFFF);
      write_reg(CSR_AMP_SCALE, 16'h0000);
      write_reg(CSR_ERR_SCALE, 16'h0000);
      write_reg(CSR_TRACK_LIMIT, 16'hFFFF);
      write_reg(CSR_DEAD_BAND, 16'h0000);
      random_phase(300, 3, 300);
      wait_drained();

      // other corner: zero rates and track limit, wide rate range and dead band, no result stalls
      write_reg(CSR_RATE_MIN, 16'h0000);
      write_reg(CSR_RATE_MAX, 16'hFFFF);
      write_reg(CSR_NOISE_RATE, 16'h0000);
      write_reg(CSR_BASELINE_RATE, 16'h0000);
      write_reg(CSR_AMP_SCALE, 16'hFFFF);
      write_reg(CSR_ERR_SCALE, 16'h0001);
      write_reg(CSR_TRACK_LIMIT, 16'h0000);
      write_reg(CSR_DEAD_BAND, 16'hFFFF);
      rsp_stall_on = 1'b0;
      random_phase(300, 5, 2000);
      wait_drained();
      rsp_stall_on = 1'b1;

      // random mid-range settings
      for (int p = 0; p < 3; p++) begin
         for (int r = 0; r < 8; r++)
            write_reg(r[3:0], 16'($urandom_range(0, 65535)));
         random_phase(230, 8, int'($urandom_range(1, 500)));
         wait_drained();
      end

      $display("covered %0d sample transactions, %0d results checked over six register settings",
         n_items, n_checked);
      if (errors == 0 && pending_results.size() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

### filelist.f
+incdir+sv
sv/abd_pkg.sv
sv/abd_chan_mem.sv
sv/abd_div.sv
sv/adaptive_baseline_denoise.sv
dv/tb.sv
